>>> design/mf2d_pkg.sv
// Shared types and constants of the 2-D median filter.
`default_nettype none

package mf2d_pkg;

	// Default sizing of the unit
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_WINDOW = 7;
	localparam int DEF_PIXEL_BITS = 8;

	// Frame height limit and row counter width (holds the height itself)
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_BITS   = 11;

	// Configuration port
	localparam int CFG_DATA_BITS  = 11;
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_WINDOW_SIZE  = 2'd2
	} cfg_reg_t;

	localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
	localparam logic [10:0] RST_FRAME_HEIGHT = 11'd1024;
	localparam logic [2:0]  RST_WINDOW_SIZE  = 3'd3;

	// Operation codes of an input request
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] pixel;
	} in_req_t;

	typedef struct packed {
		logic [7:0] median_value;
		logic [9:0] out_column;
		logic [9:0] out_row;
		logic       frame_last;
	} out_req_t;

	// Output position carried down the median pipeline
	typedef struct packed {
		logic [9:0] col;
		logic [9:0] row;
		logic       last;
	} pos_t;

endpackage

`default_nettype wire

>>> design/median_filter_2d_replicate_border_unit.sv
// Streaming 2-D median filter with replicated borders over a column-wide line store.
// Path: a released position is fetched, shifted into the window, ranked and queued.
// Throughput: one request per cycle while released positions are fetched at once;
// preload fetches at each row start and a full result queue hold the input.
// Reset: counters, handshake and queue state clear; registers go to 1024/1024/3;
// the line store is not cleared.
`default_nettype none

module median_filter_2d_replicate_border_unit #(
	parameter int MAX_WIDTH  = mf2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = mf2d_pkg::DEF_MAX_WINDOW,
	parameter int PIXEL_BITS = mf2d_pkg::DEF_PIXEL_BITS
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [mf2d_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [mf2d_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire mf2d_pkg::in_req_t                     in_item,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output mf2d_pkg::out_req_t                         out_item
);

	localparam int HALF  = MAX_WINDOW / 2;
	localparam int SIDE  = 2 * HALF + 1;
	localparam int CELLS = SIDE * SIDE;
	localparam int MID   = CELLS / 2;
	localparam int RB    = $clog2(2 * HALF + 3);
	localparam int RING  = 1 << RB;
	localparam int PB    = PIXEL_BITS;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int KB    = $clog2(MAX_WIDTH + 2 * HALF + 1);
	localparam int RWB   = mf2d_pkg::ROW_BITS;
	localparam int EB    = $clog2(HALF + 1);
	localparam int NB    = $clog2(MAX_WIDTH * mf2d_pkg::MAX_HEIGHT + 1);
	localparam int CNTB  = $clog2(CELLS);
	localparam int FD    = 8;
	localparam int FB    = $clog2(FD);

	// Configuration registers
	logic [10:0] fw_q;
	logic [10:0] fh_q;
	logic [2:0]  ws_q;
	logic        cfg_restart;

	// Effective frame geometry
	logic [WB-1:0]  w_eff;
	logic [RWB-1:0] h_eff;
	logic [EB-1:0]  e_eff;
	logic [NB-1:0]  lag;

	// Input and emit position counters
	logic [CW-1:0]  in_col_q;
	logic [RWB-1:0] in_row_q;
	logic [NB-1:0]  written_q;
	logic [CW-1:0]  emit_col_q;
	logic [RWB-1:0] emit_row_q;
	logic [NB-1:0]  emitted_q;

	logic           in_fire;
	logic           was_complete;
	logic           store_fire;
	logic           col_wrap;
	logic [NB-1:0]  written_n;
	logic           emit_hit;
	logic           emit_last;
	logic [PB-1:0]  pix;

	// Fetch engine
	logic [1:0]     credit_q;
	logic [RWB-1:0] eng_row_q;
	logic [KB-1:0]  kf_q;
	logic [FB:0]    res_q;
	logic [KB-1:0]  e2;
	logic           out_step;
	logic           kf_last;
	logic           issue;
	logic           consume;
	logic           pop;
	logic [KB-1:0]  kk;
	logic [CW-1:0]  fetch_col;
	logic [RB-1:0]  lane_sel [SIDE];
	logic [RWB+1:0] row_sum  [SIDE];
	mf2d_pkg::pos_t issue_pos;
	logic [CW-1:0]  pos_col;

	// Line store: one word per column, one lane per ring row
	logic [RING*PB-1:0] mem [MAX_WIDTH];

	// Pipeline
	logic               v_s1, o_s1;
	logic [RING*PB-1:0] rd_s1;
	logic [RB-1:0]      lane_s1 [SIDE];
	mf2d_pkg::pos_t     pos_s1;
	logic [PB-1:0]      cv [SIDE];
	logic [PB-1:0]      win_q [SIDE][SIDE];

	logic               v_s2;
	mf2d_pkg::pos_t     pos_s2;
	logic [PB-1:0]      vals [CELLS];

	logic               v_s3;
	mf2d_pkg::pos_t     pos_s3;
	logic [CELLS-1:0]   lt_s3 [CELLS];
	logic [PB-1:0]      win_s3 [CELLS];

	logic               v_s4;
	mf2d_pkg::pos_t     pos_s4;
	logic [CELLS-1:0]   hit_s4;
	logic [PB-1:0]      win_s4 [CELLS];
	logic [CNTB-1:0]    cnt [CELLS];
	logic [PB-1:0]      med;

	// Result queue
	mf2d_pkg::out_req_t fifo_q [FD];
	logic [FB-1:0]      wr_ptr_q, rd_ptr_q;
	logic [FB:0]        fcnt_q;

	// Restart the frame on a write to a defined register
	assign cfg_restart = cfg_we && (cfg_index == mf2d_pkg::REG_FRAME_WIDTH ||
		cfg_index == mf2d_pkg::REG_FRAME_HEIGHT || cfg_index == mf2d_pkg::REG_WINDOW_SIZE);

	// Clamp register values to usable geometry
	always_comb begin
		if (fw_q == '0) begin
			w_eff = WB'(1);
		end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(fw_q);
		end
		if (fh_q == '0) begin
			h_eff = RWB'(1);
		end else if (32'(fh_q) > 32'(mf2d_pkg::MAX_HEIGHT)) begin
			h_eff = RWB'(mf2d_pkg::MAX_HEIGHT);
		end else begin
			h_eff = RWB'(fh_q);
		end
		if (32'(ws_q[2:1]) > 32'(HALF)) begin
			e_eff = EB'(HALF);
		end else begin
			e_eff = EB'(ws_q[2:1]);
		end
		lag = NB'(e_eff) * NB'(w_eff) + NB'(e_eff);
	end

	// Decide storage and release of one output position per request
	always_comb begin
		in_fire      = in_valid && in_ready;
		was_complete = in_row_q >= h_eff;
		store_fire   = in_fire && (in_item.operation == mf2d_pkg::OP_PIXEL) && !was_complete;
		col_wrap     = (WB'(in_col_q) + WB'(1)) >= w_eff;
		written_n    = written_q + NB'(store_fire);
		emit_hit     = in_fire && (emit_row_q < h_eff) &&
			(was_complete || (written_n >= emitted_q + lag + NB'(1)));
		emit_last    = (emit_row_q == h_eff - RWB'(1)) && (WB'(emit_col_q) == w_eff - WB'(1));
		pix          = PB'(in_item.pixel);
	end

	// Hold at most one unfetched position so the ring never overruns the window
	assign in_ready = (credit_q == 2'd0) || consume;

	// Configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= mf2d_pkg::RST_FRAME_WIDTH;
			fh_q       <= mf2d_pkg::RST_FRAME_HEIGHT;
			ws_q       <= mf2d_pkg::RST_WINDOW_SIZE;
			in_col_q   <= '0;
			in_row_q   <= '0;
			written_q  <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			emitted_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mf2d_pkg::REG_FRAME_WIDTH: begin
					fw_q <= cfg_data;
				end
				mf2d_pkg::REG_FRAME_HEIGHT: begin
					fh_q <= cfg_data;
				end
				mf2d_pkg::REG_WINDOW_SIZE: begin
					ws_q <= cfg_data[2:0];
				end
				default: begin
				end
			endcase
			if (cfg_restart) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				written_q  <= '0;
				emit_col_q <= '0;
				emit_row_q <= '0;
				emitted_q  <= '0;
			end
		end else begin
			// advance the input position
			if (store_fire) begin
				written_q <= written_n;
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RWB'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			// advance the emit position; restart the frame after its last result
			if (emit_hit) begin
				if (emit_last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					written_q  <= '0;
					emit_col_q <= '0;
					emit_row_q <= '0;
					emitted_q  <= '0;
				end else begin
					emitted_q <= emitted_q + NB'(1);
					if ((WB'(emit_col_q) + WB'(1)) >= w_eff) begin
						emit_col_q <= '0;
						emit_row_q <= emit_row_q + RWB'(1);
					end else begin
						emit_col_q <= emit_col_q + CW'(1);
					end
				end
			end
		end
	end

	// Fetch step decode: preload steps, then one result per column
	always_comb begin
		e2       = KB'(e_eff) << 1;
		out_step = kf_q >= e2;
		kf_last  = kf_q == (KB'(w_eff) + e2 - KB'(1));
		issue    = (credit_q != 2'd0) && (!out_step || (res_q < (FB+1)'(FD)));
		consume  = issue && out_step;
		pop      = out_valid && out_ready;
		kk       = kf_q - KB'(e_eff);
		if (kf_q < KB'(e_eff)) begin
			fetch_col = '0;
		end else if (kk >= KB'(w_eff)) begin
			fetch_col = CW'(w_eff - WB'(1));
		end else begin
			fetch_col = CW'(kk);
		end
		pos_col        = CW'(kf_q - e2);
		issue_pos.col  = 10'(pos_col);
		issue_pos.row  = 10'(eng_row_q);
		issue_pos.last = (eng_row_q == h_eff - RWB'(1)) && (WB'(pos_col) == w_eff - WB'(1));
		for (int i = 0; i < SIDE; i++) begin
			row_sum[i] = (RWB+2)'(eng_row_q) + (RWB+2)'(i);
			if (row_sum[i] < (RWB+2)'(e_eff)) begin
				lane_sel[i] = '0;
			end else if ((row_sum[i] - (RWB+2)'(e_eff)) >= (RWB+2)'(h_eff)) begin
				lane_sel[i] = RB'(h_eff - RWB'(1));
			end else begin
				lane_sel[i] = RB'(row_sum[i] - (RWB+2)'(e_eff));
			end
		end
	end

	// Credit, fetch position and result reservation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q  <= '0;
			eng_row_q <= '0;
			kf_q      <= '0;
			res_q     <= '0;
		end else begin
			credit_q <= credit_q + 2'(emit_hit) - 2'(consume);
			res_q    <= res_q + (FB+1)'(consume) - (FB+1)'(pop);
			if (cfg_restart) begin
				eng_row_q <= '0;
				kf_q      <= '0;
			end else if (issue) begin
				if (kf_last) begin
					kf_q <= '0;
					if (eng_row_q == h_eff - RWB'(1)) begin
						eng_row_q <= '0;
					end else begin
						eng_row_q <= eng_row_q + RWB'(1);
					end
				end else begin
					kf_q <= kf_q + KB'(1);
				end
			end
		end
	end

	// Line store: write one lane, read a whole column
	always_ff @(posedge clk) begin
		if (store_fire) begin
			mem[in_col_q][in_row_q[RB-1:0]*PB +: PB] <= pix;
		end
		if (issue) begin
			rd_s1 <= mem[fetch_col];
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			o_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			o_s1 <= consume;
			v_s2 <= v_s1 && o_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Pick the window rows out of the fetched column
	always_comb begin
		for (int i = 0; i < SIDE; i++) begin
			cv[i] = rd_s1[lane_s1[i]*PB +: PB];
		end
	end

	// Pad cells outside the active window, half low and half high
	always_comb begin
		for (int i = 0; i < SIDE; i++) begin
			for (int j = 0; j < SIDE; j++) begin
				if (32'(i) > 32'(e2)) begin
					vals[i*SIDE+j] = (32'(i) <= 32'(HALF) + 32'(e_eff)) ? '0 : '1;
				end else if (32'(j) > 32'(e2)) begin
					vals[i*SIDE+j] = (32'(j) <= 32'(HALF) + 32'(e_eff)) ? '0 : '1;
				end else begin
					vals[i*SIDE+j] = win_q[j][i];
				end
			end
		end
	end

	// Rank each cell and select the middle one
	always_comb begin
		med = '0;
		for (int n = 0; n < CELLS; n++) begin
			cnt[n] = CNTB'($countones(lt_s3[n]));
			if (hit_s4[n]) begin
				med = med | win_s4[n];
			end
		end
	end

	// Pipeline payload: window shift, compares, ranks
	always_ff @(posedge clk) begin
		if (issue) begin
			lane_s1 <= lane_sel;
			pos_s1  <= issue_pos;
		end
		if (v_s1) begin
			win_q[0] <= cv;
			for (int j = 1; j < SIDE; j++) begin
				win_q[j] <= win_q[j-1];
			end
			pos_s2 <= pos_s1;
		end
		for (int n = 0; n < CELLS; n++) begin
			for (int m = 0; m < CELLS; m++) begin
				lt_s3[n][m] <= (vals[m] < vals[n]) || ((vals[m] == vals[n]) && (m < n));
			end
			win_s3[n] <= vals[n];
			hit_s4[n] <= cnt[n] == CNTB'(MID);
			win_s4[n] <= win_s3[n];
		end
		pos_s3 <= pos_s2;
		pos_s4 <= pos_s3;
	end

	// Result queue
	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_q[wr_ptr_q].median_value <= 8'(med);
			fifo_q[wr_ptr_q].out_column   <= pos_s4.col;
			fifo_q[wr_ptr_q].out_row      <= pos_s4.row;
			fifo_q[wr_ptr_q].frame_last   <= pos_s4.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (v_s4) begin
				wr_ptr_q <= wr_ptr_q + FB'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FB'(1);
			end
			fcnt_q <= fcnt_q + (FB+1)'(v_s4) - (FB+1)'(pop);
		end
	end

	assign out_valid = fcnt_q != '0;
	assign out_item  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> sim/median_filter_2d_replicate_border_unit_test.sv
// Testbench of the streaming 2-D median filter: directed table, extremes, then random frames.
`default_nettype none

module median_filter_2d_replicate_border_unit_test;

	localparam int RING_ROWS = 10;
	localparam int LINE_LEN = 1024;
	localparam logic [mf2d_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 24;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mf2d_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [mf2d_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	mf2d_pkg::in_req_t in_item;
	logic out_valid;
	logic out_ready;
	mf2d_pkg::out_req_t out_item;

	median_filter_2d_replicate_border_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// Predictor state
	logic [7:0] line_mem [0:RING_ROWS-1][0:LINE_LEN-1];
	logic [10:0] width_reg, height_reg;
	logic [2:0] wsize_reg;
	int in_col, in_row, em_col, em_row;

	mf2d_pkg::out_req_t median_q[$];
	int mismatches;
	int in_taken;
	bit fixed_valid;
	mf2d_pkg::out_req_t fixed_res;
	bit rx_hold_req;
	int burst_left;
	int rand_items;

	typedef struct {
		mf2d_pkg::in_req_t req;
		bit has_exp;
		mf2d_pkg::out_req_t exp;
	} dir_row_t;

	dir_row_t dir_tab [0:22];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int eff_w();
		if (width_reg == 0) return 1;
		return (width_reg > LINE_LEN) ? LINE_LEN : int'(width_reg);
	endfunction

	function automatic int eff_h();
		if (height_reg == 0) return 1;
		return (height_reg > mf2d_pkg::MAX_HEIGHT) ? mf2d_pkg::MAX_HEIGHT : int'(height_reg);
	endfunction

	function automatic int clamp_pos(int center, int e, int k, int limit);
		int v;
		v = center + k - e;
		if (v < 0) return 0;
		return (v >= limit) ? limit - 1 : v;
	endfunction

	function automatic logic [7:0] window_median(int w, int h, int e);
		logic [7:0] vals [0:48];
		logic [7:0] t;
		int n, rr, cc, j;
		n = 0;
		for (int i = 0; i < 2 * e + 1; i++) begin
			rr = clamp_pos(em_row, e, i, h) % RING_ROWS;
			for (int k = 0; k < 2 * e + 1; k++) begin
				cc = clamp_pos(em_col, e, k, w);
				vals[n] = line_mem[rr][cc];
				n++;
			end
		end
		// insertion sort, ascending
		for (int i = 1; i < n; i++) begin
			t = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > t) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = t;
		end
		return vals[n/2];
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		em_col = 0;
		em_row = 0;
	endfunction

	// Advance the predictor by one accepted request; return 1 with a result
	function automatic bit filter_step(mf2d_pkg::in_req_t r, output mf2d_pkg::out_req_t res);
		int w, h, e, lag, written, emitted;
		bit done;
		res = '0;
		w = eff_w();
		h = eff_h();
		e = wsize_reg / 2;
		lag = e * w + e;
		done = in_row >= h;
		if (r.operation == mf2d_pkg::OP_PIXEL && !done) begin
			line_mem[in_row % RING_ROWS][in_col % LINE_LEN] = r.pixel;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		written = in_row * w + in_col;
		emitted = em_row * w + em_col;
		if (em_row >= h) return 0;
		if (!(done || written >= emitted + lag + 1)) return 0;
		res.median_value = window_median(w, h, e);
		res.out_column = em_col[9:0];
		res.out_row = em_row[9:0];
		res.frame_last = (em_row == h - 1) && (em_col == w - 1);
		em_col++;
		if (em_col >= w) begin
			em_col = 0;
			em_row++;
		end
		if (em_row >= h) restart_frame();
		return 1;
	endfunction

	// Predict on accepted requests and register writes, check accepted results
	always @(posedge clk) begin
		mf2d_pkg::out_req_t res, exp;
		in_taken = in_valid && in_ready;
		if (arst_n && cfg_we) begin
			case (cfg_index)
				mf2d_pkg::REG_FRAME_WIDTH: begin
					width_reg = cfg_data;
					restart_frame();
				end
				mf2d_pkg::REG_FRAME_HEIGHT: begin
					height_reg = cfg_data;
					restart_frame();
				end
				mf2d_pkg::REG_WINDOW_SIZE: begin
					wsize_reg = cfg_data[2:0];
					restart_frame();
				end
				default: ;
			endcase
		end
		if (arst_n && in_valid && in_ready) begin
			if (filter_step(in_item, res))
				median_q.push_back(fixed_valid ? fixed_res : res);
		end
		if (arst_n && out_valid && out_ready) begin
			if (median_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_item);
			end else begin
				exp = median_q.pop_front();
				if (out_item !== exp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp, out_item);
				end
			end
		end
	end

	// Receiver: own stall pattern, plus a long hold on request
	initial begin
		int hold_cnt, mode, seg;
		hold_cnt = 0;
		mode = 0;
		seg = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				hold_cnt = 400;
			end
			if (seg == 0) begin
				seg = $urandom_range(16, 96);
				mode = $urandom_range(0, 3);
			end
			seg--;
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offer one request, in bursts with random gaps; return after acceptance
	task automatic offer(mf2d_pkg::in_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= r;
		do @(negedge clk); while (!in_taken);
	endtask

	// Hold the sender until every expected result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		while (median_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame(logic [10:0] w, logic [10:0] h, logic [10:0] ws);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= mf2d_pkg::REG_FRAME_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= mf2d_pkg::REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_index <= mf2d_pkg::REG_WINDOW_SIZE;
		cfg_data <= ws;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Stream one frame at the current sizes, with stray flushes and pixels mixed in when noisy
	task automatic run_frame(int noisy);
		int w, h, e, n, flushes;
		mf2d_pkg::in_req_t r;
		w = eff_w();
		h = eff_h();
		e = wsize_reg / 2;
		n = w * h;
		flushes = (e * w + e < n) ? e * w + e : n;
		for (int p = 0; p < n; p++) begin
			if (noisy && $urandom_range(0, 19) == 0) begin
				r.operation = mf2d_pkg::OP_FLUSH;
				r.pixel = 8'($urandom_range(0, 255));
				offer(r);
			end
			r.operation = mf2d_pkg::OP_PIXEL;
			r.pixel = rand_pixel();
			offer(r);
			rand_items++;
		end
		for (int f = 0; f < flushes; f++) begin
			r.operation = (noisy && $urandom_range(0, 9) == 0) ? mf2d_pkg::OP_PIXEL
				: mf2d_pkg::OP_FLUSH;
			r.pixel = 8'($urandom_range(0, 255));
			offer(r);
			rand_items++;
		end
	endtask

	function automatic dir_row_t mk(logic op, logic [7:0] pix, bit he,
			logic [7:0] m, logic [9:0] c, logic [9:0] rw, logic lst);
		dir_row_t d;
		d.req.operation = op;
		d.req.pixel = pix;
		d.has_exp = he;
		d.exp.median_value = m;
		d.exp.out_column = c;
		d.exp.out_row = rw;
		d.exp.frame_last = lst;
		return d;
	endfunction

	initial begin
		mf2d_pkg::in_req_t r;
		int frames;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = mf2d_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		in_item = '0;
		mismatches = 0;
		in_taken = 0;
		fixed_valid = 0;
		fixed_res = '0;
		rx_hold_req = 0;
		burst_left = 0;
		rand_items = 0;
		width_reg = mf2d_pkg::RST_FRAME_WIDTH;
		height_reg = mf2d_pkg::RST_FRAME_HEIGHT;
		wsize_reg = mf2d_pkg::RST_WINDOW_SIZE;
		restart_frame();
		foreach (line_mem[i, j]) line_mem[i][j] = '0;

		// 2x2 frame, window of one: each pixel comes straight back
		dir_tab[0] = mk(mf2d_pkg::OP_FLUSH, 8'h3C, 0, 0, 0, 0, 0);
		dir_tab[1] = mk(mf2d_pkg::OP_PIXEL, 8'hFF, 1, 8'hFF, 0, 0, 0);
		dir_tab[2] = mk(mf2d_pkg::OP_PIXEL, 8'h00, 1, 8'h00, 1, 0, 0);
		dir_tab[3] = mk(mf2d_pkg::OP_PIXEL, 8'hAA, 1, 8'hAA, 0, 1, 0);
		dir_tab[4] = mk(mf2d_pkg::OP_PIXEL, 8'h55, 1, 8'h55, 1, 1, 1);
		dir_tab[5] = mk(mf2d_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0, 0);
		// 4x3 frame, 3x3 window; a late pixel stands in for a flush
		dir_tab[6] = mk(mf2d_pkg::OP_PIXEL, 8'h00, 0, 0, 0, 0, 0);
		dir_tab[7] = mk(mf2d_pkg::OP_PIXEL, 8'hFF, 0, 0, 0, 0, 0);
		dir_tab[8] = mk(mf2d_pkg::OP_PIXEL, 8'h10, 0, 0, 0, 0, 0);
		dir_tab[9] = mk(mf2d_pkg::OP_PIXEL, 8'h80, 0, 0, 0, 0, 0);
		dir_tab[10] = mk(mf2d_pkg::OP_PIXEL, 8'hFF, 0, 0, 0, 0, 0);
		dir_tab[11] = mk(mf2d_pkg::OP_PIXEL, 8'h01, 0, 0, 0, 0, 0);
		dir_tab[12] = mk(mf2d_pkg::OP_PIXEL, 8'h7F, 0, 0, 0, 0, 0);
		dir_tab[13] = mk(mf2d_pkg::OP_PIXEL, 8'h00, 0, 0, 0, 0, 0);
		dir_tab[14] = mk(mf2d_pkg::OP_PIXEL, 8'hFE, 0, 0, 0, 0, 0);
		dir_tab[15] = mk(mf2d_pkg::OP_PIXEL, 8'h40, 0, 0, 0, 0, 0);
		dir_tab[16] = mk(mf2d_pkg::OP_PIXEL, 8'h20, 0, 0, 0, 0, 0);
		dir_tab[17] = mk(mf2d_pkg::OP_PIXEL, 8'h08, 0, 0, 0, 0, 0);
		dir_tab[18] = mk(mf2d_pkg::OP_PIXEL, 8'hC3, 0, 0, 0, 0, 0);
		dir_tab[19] = mk(mf2d_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0, 0);
		dir_tab[20] = mk(mf2d_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0, 0);
		dir_tab[21] = mk(mf2d_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0, 0);
		dir_tab[22] = mk(mf2d_pkg::OP_FLUSH, 8'h00, 0, 0, 0, 0, 0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Walk the directed table
		for (int i = 0; i < 23; i++) begin
			if (i == 0) set_frame(11'd2, 11'd2, 11'd0);
			if (i == 6) set_frame(11'd4, 11'd3, 11'd3);
			fixed_valid = dir_tab[i].has_exp;
			fixed_res = dir_tab[i].exp;
			offer(dir_tab[i].req);
		end
		fixed_valid = 0;

		// Extremes: saturated width, zero height, window of one; ignored index
		set_frame(11'h7FF, 11'd0, 11'd1);
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= 11'h7FF;
		@(negedge clk);
		cfg_we <= 1'b0;
		run_frame(0);

		// Random frames
		rand_items = 0;
		frames = 0;
		while (rand_items < 850) begin
			if (frames == 0 || $urandom_range(0, 2) == 0)
				set_frame(($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 48))
						: 11'($urandom_range(1, 12)),
					11'($urandom_range(1, 10)), 11'($urandom_range(0, 7)));
			// stall the receiver over a frame large enough to fill the block
			if (frames == 4) begin
				set_frame(11'd12, 11'd10, 11'd3);
				rx_hold_req = 1;
			end
			run_frame($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				r.operation = mf2d_pkg::OP_FLUSH;
				r.pixel = 8'($urandom_range(0, 255));
				offer(r);
			end
			frames++;
		end

		// Finish the last frame and settle
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && median_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
